@@ hdl/msp_pkg.sv @@
// Package with the item types, action codes and constants of the motor soft-start block.
package msp_pkg;

  typedef enum logic [1:0] {
    ACT_TICK       = 2'd0,
    ACT_SET_TARGET = 2'd1,
    ACT_CLEAR_LOCK = 2'd2,
    ACT_ESTOP      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_UV   = 2'd1,
    FAULT_OC   = 2'd2
  } fault_e;

  localparam logic [1:0] REG_MIN_SUPPLY  = 2'd0;
  localparam logic [1:0] REG_MAX_CURRENT = 2'd1;
  localparam logic [1:0] REG_SAG_PERCENT = 2'd2;
  localparam logic [1:0] REG_RAMP_STEP   = 2'd3;

  localparam logic [15:0] IDLE_MIN_MV     = 16'd5000;
  localparam logic [15:0] IDLE_DEFAULT_MV = 16'd12000;
  localparam logic [15:0] UV_FLOOR_MV     = 16'd1000;
  localparam logic [12:0] STEP_MIN        = 13'd26;
  localparam logic [12:0] STEP_MAX        = 13'd5120;
  localparam logic [12:0] STEP_RESET      = 13'd512;
  localparam logic [6:0]  PCT_FULL        = 7'd100;
  localparam logic [7:0]  SAG_LIMIT_MAX   = 8'd255;

  typedef struct packed {
    action_e     action;
    logic [7:0]  target_request;
    logic [15:0] current_sample_ma;
    logic [15:0] supply_sample_mv;
    logic [15:0] idle_hint_mv;
  } msp_in_t;

  typedef struct packed {
    logic [7:0] pwm_duty;
    logic       locked_out;
    logic [1:0] fault_code;
    logic [7:0] sag_ceiling;
  } msp_out_t;

endpackage

@@ hdl/motor_soft_start_protection_core.sv @@
// Top level of the pump motor PWM driver with soft-start ramp and latched protection.
//
// Each item is one action: a tick with current and supply samples, a new target duty, a clear
// of the lockout or an emergency stop, and every item returns one result with the duty, the
// lockout, the fault code and the sag ceiling as they stand after that action. The block takes
// one item per cycle while the output is not stalled; an item is held in the input register and
// its result in the result register. The rate is set by the combinational state update between
// those two registers. The user must write configuration through the APB port only while no item
// is in flight; the block does not enforce this. A ramp step write is clamped to 26..5120.
module motor_soft_start_protection_core
  import msp_pkg::*;
#(
  parameter int OC_TRIP_COUNT = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  msp_in_t     in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output msp_out_t    out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int OcW = $clog2(OC_TRIP_COUNT + 1);
  localparam logic [OcW-1:0] OcTrip = OcW'(OC_TRIP_COUNT);

  logic [15:0] min_supply_q, max_current_q;
  logic [6:0]  sag_percent_q;
  logic [12:0] ramp_step_q;
  logic [12:0] step_wr;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    step_wr = pwdata[12:0];
    if (step_wr < STEP_MIN) begin
      step_wr = STEP_MIN;
    end else if (step_wr > STEP_MAX) begin
      step_wr = STEP_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_supply_q  <= 16'd0;
      max_current_q <= 16'hFFFF;
      sag_percent_q <= PCT_FULL;
      ramp_step_q   <= STEP_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MIN_SUPPLY:  min_supply_q  <= pwdata[15:0];
        REG_MAX_CURRENT: max_current_q <= pwdata[15:0];
        REG_SAG_PERCENT: sag_percent_q <= pwdata[6:0];
        REG_RAMP_STEP:   ramp_step_q   <= step_wr;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MIN_SUPPLY:  prdata = {16'd0, min_supply_q};
      REG_MAX_CURRENT: prdata = {16'd0, max_current_q};
      REG_SAG_PERCENT: prdata = {25'd0, sag_percent_q};
      REG_RAMP_STEP:   prdata = {19'd0, ramp_step_q};
      default:         prdata = 32'd0;
    endcase
  end

  // Handshake and pipeline control.
  msp_in_t  in_q;
  msp_out_t out_q, out_d;
  logic     s1_valid_q, out_valid_q;
  logic     out_ready, process, accept;

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign process     = s1_valid_q && out_ready;
  assign in_stall_o  = s1_valid_q && !out_ready;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (process) begin
        s1_valid_q <= 1'b0;
      end
      if (process) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_item_i;
    end
    if (process) begin
      out_q <= out_d;
    end
  end

  // Controller state.
  logic [7:0]     target_q, target_d;
  logic [15:0]    accum_q, accum_d;
  logic           lock_q, lock_d;
  fault_e         fault_q, fault_d;
  logic [7:0]     sag_q, sag_d;
  logic [15:0]    snap_q, snap_d;
  logic [OcW-1:0] oc_q, oc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= 8'd0;
      accum_q  <= 16'd0;
      lock_q   <= 1'b0;
      fault_q  <= FAULT_NONE;
      sag_q    <= SAG_LIMIT_MAX;
      snap_q   <= 16'd0;
      oc_q     <= '0;
    end else if (process) begin
      target_q <= target_d;
      accum_q  <= accum_d;
      lock_q   <= lock_d;
      fault_q  <= fault_d;
      sag_q    <= sag_d;
      snap_q   <= snap_d;
      oc_q     <= oc_d;
    end
  end

  logic [15:0]    snap_tick, eff_acc, diff, accum_down;
  logic [OcW-1:0] oc_inc;
  logic [22:0]    sup_x100, snap_scaled;
  logic [6:0]     headroom;
  logic [7:0]     sag_tick, eff;
  logic [16:0]    up_sum;
  logic [13:0]    down;
  logic           sagging;

  always_comb begin
    snap_tick = snap_q;
    if (target_q == 8'd0 && in_q.supply_sample_mv > IDLE_MIN_MV) begin
      snap_tick = in_q.supply_sample_mv;
    end
    if (snap_tick < IDLE_MIN_MV) begin
      snap_tick = (in_q.idle_hint_mv > IDLE_MIN_MV) ? in_q.idle_hint_mv : IDLE_DEFAULT_MV;
    end

    oc_inc = (oc_q < OcTrip) ? oc_q + OcW'(1) : oc_q;

    headroom    = PCT_FULL - sag_percent_q;
    sup_x100    = {7'd0, in_q.supply_sample_mv} * {16'd0, PCT_FULL};
    snap_scaled = {7'd0, snap_tick} * {16'd0, headroom};
    sagging     = (sag_percent_q <= PCT_FULL) && (sup_x100 < snap_scaled);

    if (target_q != 8'd0) begin
      sag_tick = (sagging && sag_q != 8'd0) ? sag_q - 8'd1 : sag_q;
    end else begin
      sag_tick = SAG_LIMIT_MAX;
    end

    eff        = (target_q < sag_tick) ? target_q : sag_tick;
    eff_acc    = {eff, 8'd0};
    up_sum     = {1'b0, accum_q} + {4'd0, ramp_step_q};
    down       = {ramp_step_q, 1'b0};
    diff       = accum_q - eff_acc;
    accum_down = accum_q - {2'd0, down};
  end

  always_comb begin
    target_d = target_q;
    accum_d  = accum_q;
    lock_d   = lock_q;
    fault_d  = fault_q;
    sag_d    = sag_q;
    snap_d   = snap_q;
    oc_d     = oc_q;

    case (in_q.action)
      ACT_TICK: begin
        if (lock_q) begin
          target_d = 8'd0;
          accum_d  = 16'd0;
          sag_d    = SAG_LIMIT_MAX;
        end else begin
          snap_d = snap_tick;
          if (in_q.supply_sample_mv < min_supply_q && in_q.supply_sample_mv > UV_FLOOR_MV) begin
            lock_d   = 1'b1;
            fault_d  = FAULT_UV;
            target_d = 8'd0;
            accum_d  = 16'd0;
            sag_d    = SAG_LIMIT_MAX;
          end else if (in_q.current_sample_ma > max_current_q && oc_inc >= OcTrip) begin
            oc_d     = oc_inc;
            lock_d   = 1'b1;
            fault_d  = FAULT_OC;
            target_d = 8'd0;
            accum_d  = 16'd0;
            sag_d    = SAG_LIMIT_MAX;
          end else begin
            if (in_q.current_sample_ma > max_current_q) begin
              oc_d = oc_inc;
            end else if (oc_q != '0) begin
              oc_d = oc_q - OcW'(1);
            end
            sag_d = sag_tick;
            if (accum_q < eff_acc) begin
              accum_d = (up_sum > {1'b0, eff_acc}) ? eff_acc : up_sum[15:0];
            end else if (accum_q > eff_acc) begin
              accum_d = (diff <= {2'd0, down}) ? eff_acc : accum_down;
            end
          end
        end
      end
      ACT_SET_TARGET: begin
        if (!(lock_q && in_q.target_request != 8'd0)) begin
          if (target_q == 8'd0 && in_q.target_request != 8'd0) begin
            sag_d  = SAG_LIMIT_MAX;
            snap_d = 16'd0;
          end
          target_d = in_q.target_request;
        end
      end
      ACT_CLEAR_LOCK: begin
        lock_d  = 1'b0;
        fault_d = FAULT_NONE;
        oc_d    = '0;
      end
      ACT_ESTOP: begin
        target_d = 8'd0;
        accum_d  = 16'd0;
        sag_d    = SAG_LIMIT_MAX;
      end
      default: ;
    endcase

    out_d.pwm_duty    = accum_d[15:8];
    out_d.locked_out  = lock_d;
    out_d.fault_code  = fault_d;
    out_d.sag_ceiling = sag_d;
  end

endmodule

@@ sim/motor_soft_start_protection_core_tb.sv @@
// Self-checking testbench for the motor soft-start and protection core.
module motor_soft_start_protection_core_tb;
  import msp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int OC_TRIP = 3;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_PRINTS = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  msp_in_t     in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  msp_out_t    out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  motor_soft_start_protection_core #(
    .OC_TRIP_COUNT(OC_TRIP)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk = ~clk;

  // Register copies and motor state of the predictor.
  logic [15:0] cfg_min_supply = 16'd0;
  logic [15:0] cfg_max_current = 16'hFFFF;
  logic [6:0]  cfg_sag_pct = PCT_FULL;
  logic [12:0] cfg_ramp_step = STEP_RESET;

  logic [7:0]  tgt_duty = 8'd0;
  logic [15:0] duty_acc = 16'd0;
  logic        lock_flag = 1'b0;
  fault_e      fault_now = FAULT_NONE;
  logic [7:0]  sag_lim = SAG_LIMIT_MAX;
  logic [15:0] idle_snap = 16'd0;
  int unsigned oc_cnt = 0;

  msp_in_t     pending_items[$];
  msp_out_t    duty_expect_q[$];
  int unsigned n_queued = 0;
  int unsigned n_checked = 0;
  int unsigned n_mismatch = 0;
  int unsigned n_settings = 0;
  int unsigned n_uv_trips = 0;
  int unsigned n_oc_trips = 0;
  int unsigned act_count[4] = '{default: 0};

  logic        in_taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  logic        send_idle_on = 1'b0;
  logic        recv_idle_on = 1'b0;

  function automatic void motor_halt();
    tgt_duty = 8'd0;
    duty_acc = 16'd0;
    sag_lim = SAG_LIMIT_MAX;
  endfunction

  function automatic void motor_tick(logic [15:0] cur, logic [15:0] sup, logic [15:0] hint);
    int unsigned acc;
    int unsigned eff_acc;
    int unsigned step;
    int unsigned sup_w;
    int unsigned pct;
    if (lock_flag) begin
      motor_halt();
      return;
    end
    if (tgt_duty == 8'd0 && sup > IDLE_MIN_MV) idle_snap = sup;
    if (idle_snap < IDLE_MIN_MV) idle_snap = (hint > IDLE_MIN_MV) ? hint : IDLE_DEFAULT_MV;
    if (sup < cfg_min_supply && sup > UV_FLOOR_MV) begin
      lock_flag = 1'b1;
      fault_now = FAULT_UV;
      n_uv_trips++;
      motor_halt();
      return;
    end
    if (cur > cfg_max_current) begin
      if (oc_cnt < OC_TRIP) oc_cnt++;
      if (oc_cnt >= OC_TRIP) begin
        lock_flag = 1'b1;
        fault_now = FAULT_OC;
        n_oc_trips++;
        motor_halt();
        return;
      end
    end else if (oc_cnt > 0) begin
      oc_cnt--;
    end
    if (tgt_duty != 8'd0) begin
      sup_w = sup;
      pct = cfg_sag_pct;
      if (pct <= 100 && sup_w * 100 < idle_snap * (100 - pct)) begin
        if (sag_lim != 8'd0) sag_lim--;
      end
    end else begin
      sag_lim = SAG_LIMIT_MAX;
    end
    eff_acc = ((tgt_duty < sag_lim) ? tgt_duty : sag_lim) << 8;
    acc = duty_acc;
    step = cfg_ramp_step;
    if (acc < eff_acc) begin
      acc += step;
      if (acc > eff_acc) acc = eff_acc;
    end else if (acc > eff_acc) begin
      if (acc - eff_acc <= 2 * step) acc = eff_acc;
      else acc -= 2 * step;
    end
    duty_acc = 16'(acc);
  endfunction

  function automatic msp_out_t motor_predict(msp_in_t it);
    msp_out_t r;
    case (it.action)
      ACT_TICK: begin
        motor_tick(it.current_sample_ma, it.supply_sample_mv, it.idle_hint_mv);
      end
      ACT_SET_TARGET: begin
        if (!(lock_flag && it.target_request != 8'd0)) begin
          if (tgt_duty == 8'd0 && it.target_request != 8'd0) begin
            sag_lim = SAG_LIMIT_MAX;
            idle_snap = 16'd0;
          end
          tgt_duty = it.target_request;
        end
      end
      ACT_CLEAR_LOCK: begin
        lock_flag = 1'b0;
        fault_now = FAULT_NONE;
        oc_cnt = 0;
      end
      default: begin
        motor_halt();
      end
    endcase
    r.pwm_duty = duty_acc[15:8];
    r.locked_out = lock_flag;
    r.fault_code = fault_now;
    r.sag_ceiling = sag_lim;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic msp_in_t make_item();
    msp_in_t it;
    int unsigned sel;
    int unsigned base;
    int unsigned hi;
    sel = $urandom_range(0, 99);
    if (sel < 62) it.action = ACT_TICK;
    else if (sel < 82) it.action = ACT_SET_TARGET;
    else if (sel < 94) it.action = ACT_CLEAR_LOCK;
    else it.action = ACT_ESTOP;

    sel = $urandom_range(0, 9);
    if (sel == 0) it.target_request = 8'd0;
    else if (sel == 1) it.target_request = 8'd255;
    else it.target_request = 8'($urandom_range(0, 255));

    sel = $urandom_range(0, 99);
    if (sel < 78) it.current_sample_ma = 16'($urandom_range(0, cfg_max_current));
    else if (sel < 93 && cfg_max_current != 16'hFFFF)
      it.current_sample_ma = 16'($urandom_range(cfg_max_current + 1, 65535));
    else it.current_sample_ma = 16'($urandom_range(0, 65535));

    base = (cfg_min_supply > 9000) ? cfg_min_supply : 9000;
    hi = (base + 5000 > 65535) ? 65535 : base + 5000;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      it.supply_sample_mv = 16'($urandom_range(base, hi));
    end else if (sel < 75) begin
      it.supply_sample_mv = 16'($urandom_range(5001, 10000));
    end else if (sel < 85) begin
      case ($urandom_range(0, 7))
        0: it.supply_sample_mv = 16'd0;
        1: it.supply_sample_mv = UV_FLOOR_MV;
        2: it.supply_sample_mv = UV_FLOOR_MV + 16'd1;
        3: it.supply_sample_mv = IDLE_MIN_MV;
        4: it.supply_sample_mv = IDLE_MIN_MV + 16'd1;
        5: it.supply_sample_mv = 16'hFFFF;
        6: it.supply_sample_mv = cfg_min_supply;
        default: it.supply_sample_mv = (cfg_min_supply != 16'd0) ? cfg_min_supply - 16'd1 : 16'd0;
      endcase
    end else begin
      it.supply_sample_mv = 16'($urandom_range(0, 65535));
    end

    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      it.idle_hint_mv = 16'($urandom_range(5001, 15000));
    end else if (sel < 70) begin
      case ($urandom_range(0, 3))
        0: it.idle_hint_mv = 16'd0;
        1: it.idle_hint_mv = IDLE_MIN_MV;
        2: it.idle_hint_mv = IDLE_MIN_MV + 16'd1;
        default: it.idle_hint_mv = 16'hFFFF;
      endcase
    end else begin
      it.idle_hint_mv = 16'($urandom_range(0, 65535));
    end
    return it;
  endfunction

  function automatic msp_in_t mk(action_e a, logic [7:0] tr, logic [15:0] cur,
                                 logic [15:0] sup, logic [15:0] hint);
    msp_in_t it;
    it.action = a;
    it.target_request = tr;
    it.current_sample_ma = cur;
    it.supply_sample_mv = sup;
    it.idle_hint_mv = hint;
    return it;
  endfunction

  task automatic queue_item(msp_in_t it);
    pending_items.push_back(it);
    n_queued++;
  endtask

  task automatic report_mismatch(string msg);
    n_mismatch++;
    if (n_mismatch <= MAX_PRINTS) $display("mismatch at result %0d: %s", n_checked, msg);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    logic [12:0] step;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MIN_SUPPLY:  cfg_min_supply = val[15:0];
      REG_MAX_CURRENT: cfg_max_current = val[15:0];
      REG_SAG_PERCENT: cfg_sag_pct = val[6:0];
      default: begin
        step = val[12:0];
        if (step < STEP_MIN) step = STEP_MIN;
        if (step > STEP_MAX) step = STEP_MAX;
        cfg_ramp_step = step;
      end
    endcase
  endtask

  task automatic apply_settings(logic [31:0] min_mv, logic [31:0] max_ma,
                                logic [31:0] sag, logic [31:0] step);
    reg_write(REG_MIN_SUPPLY, min_mv);
    reg_write(REG_MAX_CURRENT, max_ma);
    reg_write(REG_SAG_PERCENT, sag);
    reg_write(REG_RAMP_STEP, step);
    n_settings++;
  endtask

  task automatic wait_drained();
    while (n_checked != n_queued) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
        if (send_idle_on) gap_left = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    msp_out_t want;
    if (in_valid && !in_stall) begin
      duty_expect_q.push_back(motor_predict(in_item));
      act_count[in_item.action]++;
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
    if (out_valid && !out_stall) begin
      if (duty_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_item));
      end else begin
        want = duty_expect_q.pop_front();
        if (out_item.pwm_duty !== want.pwm_duty)
          report_mismatch($sformatf("pwm_duty got %0d expected %0d",
                                    out_item.pwm_duty, want.pwm_duty));
        if (out_item.locked_out !== want.locked_out)
          report_mismatch($sformatf("locked_out got %0d expected %0d",
                                    out_item.locked_out, want.locked_out));
        if (out_item.fault_code !== want.fault_code)
          report_mismatch($sformatf("fault_code got %0d expected %0d",
                                    out_item.fault_code, want.fault_code));
        if (out_item.sag_ceiling !== want.sag_ceiling)
          report_mismatch($sformatf("sag_ceiling got %0d expected %0d",
                                    out_item.sag_ceiling, want.sag_ceiling));
        n_checked++;
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int n;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    apply_settings(32'd9000, 32'd2000, 32'd10, 32'd5120);
    queue_item(mk(ACT_TICK, 8'd0, 16'd0, 16'd0, 16'd0));
    queue_item(mk(ACT_SET_TARGET, 8'd200, 16'd0, 16'd0, 16'd0));
    queue_item(mk(ACT_TICK, 8'd0, 16'd0, 16'd1000, 16'd7000));
    queue_item(mk(ACT_SET_TARGET, 8'd0, 16'd0, 16'd0, 16'd0));
    queue_item(mk(ACT_SET_TARGET, 8'd255, 16'd0, 16'd0, 16'd0));
    queue_item(mk(ACT_TICK, 8'd0, 16'd2000, 16'd12000, 16'd0));
    queue_item(mk(ACT_TICK, 8'd0, 16'd2001, 16'd12000, 16'hFFFF));
    queue_item(mk(ACT_TICK, 8'd0, 16'd0, 16'hFFFF, 16'hFFFF));
    queue_item(mk(ACT_TICK, 8'd0, 16'hFFFF, 16'd12000, 16'd0));
    queue_item(mk(ACT_TICK, 8'd0, 16'hFFFF, 16'd12000, 16'd0));
    queue_item(mk(ACT_TICK, 8'd0, 16'hFFFF, 16'd12000, 16'd0));
    queue_item(mk(ACT_TICK, 8'd0, 16'd0, 16'd12000, 16'd0));
    queue_item(mk(ACT_SET_TARGET, 8'd100, 16'd0, 16'd0, 16'd0));
    queue_item(mk(ACT_SET_TARGET, 8'd0, 16'd0, 16'd0, 16'd0));
    queue_item(mk(ACT_CLEAR_LOCK, 8'd0, 16'd0, 16'd0, 16'd0));
    queue_item(mk(ACT_SET_TARGET, 8'd255, 16'd0, 16'd0, 16'd0));
    queue_item(mk(ACT_TICK, 8'd0, 16'd0, 16'd9000, 16'd0));
    queue_item(mk(ACT_TICK, 8'd0, 16'd0, 16'd8999, 16'd0));
    queue_item(mk(ACT_CLEAR_LOCK, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    queue_item(mk(ACT_SET_TARGET, 8'd255, 16'd0, 16'd0, 16'd0));
    queue_item(mk(ACT_TICK, 8'd0, 16'd0, 16'd12000, 16'd0));
    queue_item(mk(ACT_SET_TARGET, 8'd10, 16'd0, 16'd0, 16'd0));
    queue_item(mk(ACT_TICK, 8'd0, 16'd0, 16'd12000, 16'd0));
    queue_item(mk(ACT_ESTOP, 8'd0, 16'd0, 16'd0, 16'd0));
    queue_item(mk(ACT_TICK, 8'd0, 16'd0, 16'd0, 16'hFFFF));

    for (int ph = 0; ph < 9; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          apply_settings(32'd0, 32'd65535, 32'd100, 32'd512);
          send_idle_on = 1'b0;
          recv_idle_on = 1'b0;
          n = 150;
        end
        1: begin
          apply_settings(32'd6000, 32'd3000, 32'd0, 32'd0);
          send_idle_on = 1'b1;
          recv_idle_on = 1'b1;
          n = 200;
        end
        2: begin
          apply_settings(32'd65535, 32'd0, 32'd127, 32'd8191);
          send_idle_on = 1'b1;
          recv_idle_on = 1'b0;
          n = 60;
        end
        default: begin
          apply_settings({16'($urandom_range(0, 65535)), 16'($urandom_range(0, 11000))},
                         {16'($urandom_range(0, 65535)), 16'($urandom_range(500, 65535))},
                         {25'($urandom), 7'($urandom_range(0, 127))},
                         $urandom);
          send_idle_on = (ph != 3) && ($urandom_range(0, 3) != 0);
          recv_idle_on = ($urandom_range(0, 3) != 0);
          n = 200;
        end
      endcase
      if (ph == 3) holds_asked++;
      for (int k = 0; k < n; k++) begin
        if (ph == 4 && k == n / 2) wait_drained();
        queue_item(make_item());
      end
    end
    wait_drained();

    if (duty_expect_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", duty_expect_q.size()));
    $display("summary: %0d results, %0d settings, tick %0d, target %0d, clear %0d, stop %0d",
             n_checked, n_settings, act_count[ACT_TICK], act_count[ACT_SET_TARGET],
             act_count[ACT_CLEAR_LOCK], act_count[ACT_ESTOP]);
    $display("summary: %0d undervoltage and %0d overcurrent lockouts, %0d mismatches",
             n_uv_trips, n_oc_trips, n_mismatch);
    if (n_mismatch == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ motor_soft_start_protection_core.f @@
hdl/msp_pkg.sv
hdl/motor_soft_start_protection_core.sv
sim/motor_soft_start_protection_core_tb.sv
